[rtl/chained_hash_table_insert_search_macros.svh]
// assertion macros for the chained hash table
`ifndef CHAINED_HASH_TABLE_INSERT_SEARCH_MACROS_SVH
`define CHAINED_HASH_TABLE_INSERT_SEARCH_MACROS_SVH

// same-cycle implication
`define CHT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cht assertion failed");

// next-cycle implication
`define CHT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cht assertion failed");

`endif

[rtl/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// constants and status codes of the chained hash table
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int unsigned MaxBuckets = 1024;
  localparam int unsigned MaxEntries = 256;
  localparam int unsigned MaxChars   = 20;

  localparam int unsigned BucketW = $clog2(MaxBuckets);
  localparam int unsigned EntryW  = $clog2(MaxEntries);
  localparam int unsigned CntW    = $clog2(MaxChars + 2);
  localparam int unsigned ChrAW   = $clog2(MaxEntries * MaxChars);

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_POOL_FULL = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_BUCKET_COUNT = 1'b0,
    CFG_HASH_MULT    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CntW-1:0]   len;
    logic              nxt_vld;
    logic [EntryW-1:0] nxt;
  } meta_t;

  // start of an entry in the character pool, e * MaxChars
  function automatic logic [ChrAW-1:0] chr_base(input logic [EntryW-1:0] e);
    chr_base = ChrAW'(e * MaxChars);
  endfunction

endpackage

[rtl/chained_hash_table_insert_search.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_insert_search
// polynomial string hash with separate-chaining insert and search
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the block is idle and folded into
// the hash. The last character starts a bit-serial modulo, then a bucket head
// read; an insert ends there, a search walks the chain with one synchronous
// read per entry header and per compared character. After reset the bucket
// head memory is cleared, one entry a cycle, during which no character is
// taken.
`include "chained_hash_table_insert_search_macros.svh"

module chained_hash_table_insert_search import cht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [6:0]  ch_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [9:0]  bucket_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_DIV     = 8'b0000_0100,
    S_HEAD_RD = 8'b0000_1000,
    S_HEAD_WT = 8'b0001_0000,
    S_META_WT = 8'b0010_0000,
    S_CHR_WT  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [10:0] bcount_q;
  logic [31:0] mult_q;
  logic [31:0] hash_q, hash_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [6:0] buf_q [MaxChars];
  logic [EntryW:0] used_q, used_d;
  logic op_q, op_d;
  logic [31:0] dvd_q, dvd_d;
  logic [10:0] rem_q, rem_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic [BucketW-1:0] clr_q;
  logic [EntryW-1:0] cur_q, cur_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic link_v_q, link_v_d;
  logic [EntryW-1:0] link_q, link_d;
  logic [2:0] res_q, res_d;
  logic out_valid_q;
  logic [2:0] status_q;
  logic [9:0] bucket_q;

  // memories
  logic [EntryW:0] head_mem [MaxBuckets];
  meta_t           meta_mem [MaxEntries];
  logic [6:0]      chr_mem  [MaxEntries * MaxChars];
  logic [EntryW:0] head_rd_q;
  meta_t           meta_rd_q;
  logic [6:0]      chr_rd_q;

  logic accept, load_out;
  logic [10:0] n_eff;
  logic [11:0] shl;
  logic head_we;
  logic [BucketW-1:0] head_wa;
  logic [EntryW:0] head_wd;
  logic meta_we;
  logic chr_we;
  logic [ChrAW-1:0] chr_wa, chr_ra;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign load_out    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    n_eff = bcount_q;
    if (bcount_q == 11'd0) n_eff = 11'd1;
    else if (bcount_q > 11'(MaxBuckets)) n_eff = 11'(MaxBuckets);
  end

  assign shl = {rem_q, dvd_q[31]};

  always_comb begin
    state_d  = state_q;
    hash_d   = hash_q;
    cnt_d    = cnt_q;
    used_d   = used_q;
    op_d     = op_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    cur_d    = cur_q;
    idx_d    = idx_q;
    link_v_d = link_v_q;
    link_d   = link_q;
    res_d    = res_q;
    head_we  = 1'b0;
    head_wa  = rem_q[BucketW-1:0];
    head_wd  = {1'b1, used_q[EntryW-1:0]};
    meta_we  = 1'b0;
    chr_we   = 1'b0;
    chr_wa   = chr_base(used_q[EntryW-1:0]) + ChrAW'(cnt_q);
    case (state_q)
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_q;
        head_wd = '0;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          hash_d = hash_q * mult_q + {25'd0, ch_i};
          if (cnt_q < CntW'(MaxChars)) begin
            cnt_d  = cnt_q + 1'b1;
            // characters go straight into the next free entry
            chr_we = !used_q[EntryW];
          end else begin
            cnt_d = CntW'(MaxChars + 1);
          end
          if (last_char_i) begin
            op_d    = op_i;
            dvd_d   = hash_d;
            rem_d   = '0;
            dcnt_d  = '0;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (shl >= {1'b0, n_eff}) rem_d = 11'(shl - {1'b0, n_eff});
        else rem_d = shl[10:0];
        dvd_d  = {dvd_q[30:0], 1'b0};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == 5'd31) state_d = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        if (cnt_q > CntW'(MaxChars)) begin
          res_d   = ST_TOO_LONG;
          state_d = S_DONE;
        end else if (!op_q && used_q[EntryW]) begin
          res_d   = ST_POOL_FULL;
          state_d = S_DONE;
        end else begin
          state_d = S_HEAD_WT;
        end
      end
      S_HEAD_WT: begin
        if (!op_q) begin
          meta_we = 1'b1;
          head_we = 1'b1;
          used_d  = used_q + 1'b1;
          res_d   = ST_STORED;
          state_d = S_DONE;
        end else if (!head_rd_q[EntryW]) begin
          res_d   = ST_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          cur_d   = head_rd_q[EntryW-1:0];
          state_d = S_META_WT;
        end
      end
      S_META_WT: begin
        link_v_d = meta_rd_q.nxt_vld;
        link_d   = meta_rd_q.nxt;
        if (meta_rd_q.len == cnt_q) begin
          idx_d   = '0;
          state_d = S_CHR_WT;
        end else if (meta_rd_q.nxt_vld) begin
          cur_d = meta_rd_q.nxt;
        end else begin
          res_d   = ST_NOT_FOUND;
          state_d = S_DONE;
        end
      end
      S_CHR_WT: begin
        if (chr_rd_q != buf_q[idx_q]) begin
          if (link_v_q) begin
            cur_d   = link_q;
            state_d = S_META_WT;
          end else begin
            res_d   = ST_NOT_FOUND;
            state_d = S_DONE;
          end
        end else if (idx_q == cnt_q - 1'b1) begin
          res_d   = ST_FOUND;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (load_out) begin
          hash_d  = '0;
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign chr_ra = chr_base(cur_d) + ChrAW'(idx_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      bcount_q    <= 11'd16;
      mult_q      <= 32'd31;
      hash_q      <= '0;
      cnt_q       <= '0;
      used_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_BUCKET_COUNT) bcount_q <= cfg_data_i[10:0];
        else mult_q <= cfg_data_i;
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    dcnt_q   <= dcnt_d;
    cur_q    <= cur_d;
    idx_q    <= idx_d;
    link_v_q <= link_v_d;
    link_q   <= link_d;
    res_q    <= res_d;
    if (accept && cnt_q < CntW'(MaxChars)) buf_q[cnt_q] <= ch_i;
    if (load_out) begin
      status_q <= res_q;
      bucket_q <= rem_q[9:0];
    end
  end

  // bucket heads: valid bit and entry pointer
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[rem_q[BucketW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[used_q[EntryW-1:0]] <= '{len: cnt_q,
        nxt_vld: head_rd_q[EntryW], nxt: head_rd_q[EntryW-1:0]};
    meta_rd_q <= meta_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (chr_we) chr_mem[chr_wa] <= ch_i;
    chr_rd_q <= chr_mem[chr_ra];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign bucket_o    = bucket_q;

  `CHT_ASSERT_NOW(a_used_bound, 1'b1, used_q <= (EntryW+1)'(MaxEntries))
  `CHT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(MaxChars + 1))
  `CHT_ASSERT_NEXT(a_last_div, accept && last_char_i, state_q == S_DIV)
  `CHT_ASSERT_NEXT(a_insert_alloc, state_q == S_HEAD_WT && !op_q,
                   used_q == $past(used_q) + 1'b1)

endmodule
